// File: hdl/cbp_pkg.sv
// Shared constants for the code/symbol bit packer.
package cbp_pkg;

    // Field widths of one input transaction
    localparam int CODE_W = 16;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;

    // Byte size and accumulator holding width
    localparam int BYTE_BITS = 8;
    localparam int HELD_BITS = 7;
    localparam int CNT_W     = 3;

    // Command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Job queue between front and back
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

endpackage

// File: hdl/code_symbol_bit_packer.sv
// Top level of the LSB-first code/symbol bit packer.
// Usage:
//   Input side is a queue: drive command/code/symbol/code_length and raise push;
//   the transaction is taken on a clock edge where push is high and full is low.
//   command 0 appends the low code_length bits of code (length saturates at
//   MAX_CODE_BITS) and then the 8 symbol bits; command 1 flushes the partial
//   byte, zero padded. Output side is a queue too: while empty is low, out_byte
//   and last show the oldest byte; it is taken when pop is high.
//   Each append yields 1 to 3 bytes, a flush 0 or 1; last marks the final byte
//   of a transaction. The first byte passes the job queue and the back end's job register before it shows.
//   Throughput: the back end drains one byte per cycle while the output is not
//   stalled, so an item holds it until every byte it produces has left.
//   A two-entry job queue lets the front keep accepting while the output
//   stalls; when the receiver stops popping the queue fills and full rises.
//   Reset (rst_n low, asynchronous) empties all queues and clears held bits.
module code_symbol_bit_packer #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          command,
    input  logic [cbp_pkg::CODE_W-1:0]    code,
    input  logic [cbp_pkg::SYM_W-1:0]     symbol,
    input  logic [cbp_pkg::LEN_W-1:0]     code_length,
    output logic                          empty,
    input  logic                          pop,
    output logic [cbp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                          last
);

    localparam int ACC_W  = cbp_pkg::HELD_BITS + MAX_CODE_BITS + cbp_pkg::BYTE_BITS;
    localparam int MAXB   = ACC_W / cbp_pkg::BYTE_BITS;
    localparam int DATA_W = MAXB * cbp_pkg::BYTE_BITS;
    localparam int NB_W   = $clog2(MAXB + 1);
    localparam int JOB_W  = DATA_W + NB_W;

    logic              accept;
    logic              job_push;
    logic [DATA_W-1:0] f_data;
    logic [NB_W-1:0]   f_bytes;
    logic              q_valid;
    logic              q_pop;
    logic [JOB_W-1:0]  q_rd;

    assign accept = push && !full;

    cbp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .DATA_W        (DATA_W),
        .NB_W          (NB_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .code        (code),
        .symbol      (symbol),
        .code_length (code_length),
        .job_push    (job_push),
        .job_data    (f_data),
        .job_bytes   (f_bytes)
    );

    cbp_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data ({f_bytes, f_data}),
        .q_full  (full),
        .q_valid (q_valid),
        .rd_en   (q_pop),
        .rd_data (q_rd)
    );

    cbp_back #(
        .DATA_W (DATA_W),
        .NB_W   (NB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_data  (q_rd[DATA_W-1:0]),
        .job_bytes (q_rd[JOB_W-1:DATA_W]),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// File: hdl/cbp_front.sv
// Front end: merges each transaction into the bit accumulator and issues byte jobs.
module cbp_front #(
    parameter int MAX_CODE_BITS = 16,
    parameter int DATA_W        = 24,
    parameter int NB_W          = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        command,
    input  logic [cbp_pkg::CODE_W-1:0]  code,
    input  logic [cbp_pkg::SYM_W-1:0]   symbol,
    input  logic [cbp_pkg::LEN_W-1:0]   code_length,
    output logic                        job_push,
    output logic [DATA_W-1:0]           job_data,
    output logic [NB_W-1:0]             job_bytes
);

    localparam int ACC_W = cbp_pkg::HELD_BITS + MAX_CODE_BITS + cbp_pkg::BYTE_BITS;
    localparam int N_W   = $clog2(ACC_W + 1);
    localparam int SH_W  = NB_W + 3;

    logic [cbp_pkg::HELD_BITS-1:0] held_reg, held_next;
    logic [cbp_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    logic [cbp_pkg::LEN_W-1:0]     len_sat;
    logic [cbp_pkg::CODE_W:0]      mask_wide;
    logic [cbp_pkg::CODE_W-1:0]    code_m;
    logic [ACC_W-1:0]              acc;
    logic [N_W-1:0]                sym_pos;
    logic [N_W-1:0]                n_total;
    logic [NB_W-1:0]               nb_append;
    logic [SH_W-1:0]               drop_bits;
    logic [ACC_W-1:0]              acc_rest;

    // Append path: saturate length, mask code, merge into accumulator
    always_comb
    begin
        if (code_length > cbp_pkg::LEN_W'(MAX_CODE_BITS))
            len_sat = cbp_pkg::LEN_W'(MAX_CODE_BITS);
        else
            len_sat = code_length;
        mask_wide = ~({(cbp_pkg::CODE_W + 1){1'b1}} << len_sat);
        code_m    = code & mask_wide[cbp_pkg::CODE_W-1:0];
        sym_pos   = N_W'(cnt_reg) + N_W'(len_sat);
        n_total   = sym_pos + N_W'(cbp_pkg::BYTE_BITS);
        acc       = ACC_W'(held_reg)
                  | (ACC_W'(code_m) << cnt_reg)
                  | (ACC_W'(symbol) << sym_pos);
        nb_append = NB_W'(n_total >> 3);
        drop_bits = {nb_append, 3'b000};
        acc_rest  = acc >> drop_bits;
    end

    // Job select and next accumulator state
    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        job_push  = 1'b0;
        job_data  = acc[DATA_W-1:0];
        job_bytes = nb_append;
        if (command == cbp_pkg::CMD_FLUSH)
        begin
            job_data  = DATA_W'(held_reg);
            job_bytes = (cnt_reg != '0) ? NB_W'(1) : '0;
            if (accept)
            begin
                job_push  = (cnt_reg != '0);
                held_next = '0;
                cnt_next  = '0;
            end
        end
        else if (accept)
        begin
            job_push  = (nb_append != '0);
            held_next = acc_rest[cbp_pkg::HELD_BITS-1:0];
            cnt_next  = n_total[cbp_pkg::CNT_W-1:0];
        end
    end

    // Held bits and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: hdl/cbp_queue.sv
// Short job queue that decouples the front end from the byte drain.
module cbp_queue #(
    parameter int W = 26
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         q_full,
    output logic         q_valid,
    input  logic         rd_en,
    output logic [W-1:0] rd_data
);

    logic [W-1:0]                   mem_reg [cbp_pkg::JOB_DEPTH];
    logic [cbp_pkg::JOB_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cbp_pkg::JOB_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cbp_pkg::JOB_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           do_wr, do_rd;

    assign q_full  = (cnt_reg == cbp_pkg::JOB_CNT_W'(cbp_pkg::JOB_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == cbp_pkg::JOB_PTR_W'(cbp_pkg::JOB_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == cbp_pkg::JOB_PTR_W'(cbp_pkg::JOB_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: hdl/cbp_back.sv
// Back end: drains the job one byte per cycle to the output register unless it stalls.
module cbp_back #(
    parameter int DATA_W = 24,
    parameter int NB_W   = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  logic [DATA_W-1:0]             job_data,
    input  logic [NB_W-1:0]               job_bytes,
    output logic                          job_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [cbp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                          last
);

    logic [DATA_W-1:0]             data_reg, data_next;
    logic [NB_W-1:0]               left_reg, left_next;
    logic                          ovalid_reg, ovalid_next;
    logic [cbp_pkg::BYTE_BITS-1:0] obyte_reg, obyte_next;
    logic                          olast_reg, olast_next;
    logic                          advance;

    assign empty    = !ovalid_reg;
    assign out_byte = obyte_reg;
    assign last     = olast_reg;

    // Move a byte when the output slot is free or being taken this cycle
    always_comb
    begin
        advance     = (left_reg != '0) && (!ovalid_reg || pop);
        job_pop     = job_valid && ((left_reg == '0) || (advance && left_reg == NB_W'(1)));
        data_next   = data_reg;
        left_next   = left_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg;
        if (pop && ovalid_reg)
            ovalid_next = 1'b0;
        if (advance)
        begin
            obyte_next  = data_reg[cbp_pkg::BYTE_BITS-1:0];
            olast_next  = (left_reg == NB_W'(1));
            ovalid_next = 1'b1;
            data_next   = data_reg >> cbp_pkg::BYTE_BITS;
            left_next   = left_reg - 1'b1;
        end
        if (job_pop)
        begin
            data_next = job_data;
            left_next = job_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule
